// ----- rtl/core/fdmd_pkg.sv -----
// Shared constants and control/status types for the frame-difference motion detector.
package fdmd_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int LUMA_W   = 8;
  localparam int FW_W     = 10;
  localparam int FH_W     = 9;
  localparam int THR_W    = 8;
  localparam int SUM_W    = 25;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [FW_W-1:0]  FW_RESET  = 10'd320;
  localparam logic [FH_W-1:0]  FH_RESET  = 9'd240;
  localparam logic [THR_W-1:0] THR_RESET = 8'd10;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic capture;     // pixel transfer: latch pixel, start store read
    logic accumulate;  // add difference, write store, advance counters
    logic load_bound;  // form threshold * width * height
    logic load_out;    // move frame result into the output register
  } fdmd_cmd_t;

  typedef struct packed {
    logic frame_end;   // current pixel is the last of its frame
    logic out_busy;    // output register holds a result not yet taken
  } fdmd_status_t;

endpackage

// ----- rtl/core/fdmd_ctrl.sv -----
// Controller state machine sequencing pixel accumulation and frame results.
module fdmd_ctrl
  import fdmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  fdmd_status_t status,
  output fdmd_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ACC   = 2'd1;
  localparam logic [1:0] ST_BOUND = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    in_ready        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
        state_nxt      = status.frame_end ? ST_BOUND : ST_IDLE;
      end
      ST_BOUND: begin
        cmd.load_bound = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        // Hold here until the previous result has been taken.
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/fdmd_datapath.sv -----
// Datapath: frame store, position counters, difference sum, bound and output register.
module fdmd_datapath
  import fdmd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FW_W-1:0]   frame_width,
  input  logic [FH_W-1:0]   frame_height,
  input  logic [THR_W-1:0]  motion_threshold,
  input  logic [LUMA_W-1:0] in_luma,
  input  fdmd_cmd_t         cmd,
  output fdmd_status_t      status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_compared,
  output logic              out_motion_detected,
  output logic [SUM_W-1:0]  out_difference_sum
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
  localparam int AREA_W = WD_W + HD_W;
  localparam int BND_W  = AREA_W + THR_W;
  localparam int CMP_W  = (BND_W > SUM_W) ? BND_W : SUM_W;

  logic [LUMA_W-1:0] mem [DEPTH];

  logic [LUMA_W-1:0] pix_r;
  logic [LUMA_W-1:0] rd_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              have_ref_r;
  logic [AREA_W-1:0] area_r;
  logic [BND_W-1:0]  bound_r;
  logic              out_valid_r;
  logic              out_compared_r;
  logic              out_motion_r;
  logic [SUM_W-1:0]  out_sum_r;

  logic [WD_W-1:0]   w_c;
  logic [HD_W-1:0]   h_c;
  logic [ADDR_W-1:0] addr;
  logic [LUMA_W-1:0] diff;
  logic              last_col;
  logic              last_row;
  logic              motion;

  // Zero acts as one, anything beyond the store size acts as the maximum.
  always_comb begin
    if (frame_width == '0) begin
      w_c = WD_W'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_c = WD_W'(MAX_WIDTH);
    end else begin
      w_c = WD_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_c = HD_W'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_c = HD_W'(MAX_HEIGHT);
    end else begin
      h_c = HD_W'(frame_height);
    end
  end

  assign addr     = ADDR_W'(row_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_r);
  assign diff     = (pix_r >= rd_r) ? (pix_r - rd_r) : (rd_r - pix_r);
  // A counter at or past the last index ends its row or frame, so a shrink
  // of the dimensions mid-frame closes early instead of running on.
  assign last_col = (32'(col_r) + 32'd1) >= 32'(w_c);
  assign last_row = (32'(row_r) + 32'd1) >= 32'(h_c);
  assign motion   = CMP_W'(sum_r) >= CMP_W'(bound_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    sum_nxt = sum_r;
    if (cmd.accumulate) begin
      if (have_ref_r) begin
        sum_nxt = sum_r + SUM_W'(diff);
      end
      if (!last_col) begin
        col_nxt = col_r + COL_W'(1);
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end
    end
    if (cmd.load_out) begin
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_r  <= mem[addr];
      pix_r <= in_luma;
    end
    if (cmd.accumulate) begin
      mem[addr] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    area_r <= AREA_W'(w_c) * AREA_W'(h_c);
    if (cmd.load_bound) begin
      bound_r <= BND_W'(area_r) * BND_W'(motion_threshold);
    end
    if (cmd.load_out) begin
      out_compared_r <= have_ref_r;
      out_motion_r   <= have_ref_r & motion;
      out_sum_r      <= have_ref_r ? sum_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      sum_r       <= '0;
      have_ref_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      sum_r <= sum_nxt;
      if (cmd.load_out) begin
        have_ref_r  <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.frame_end = last_col & last_row;
  assign status.out_busy  = out_valid_r & ~out_ready;

  assign out_valid           = out_valid_r;
  assign out_compared        = out_compared_r;
  assign out_motion_detected = out_motion_r;
  assign out_difference_sum  = out_sum_r;

endmodule

// ----- rtl/core/frame_difference_motion_detect_top.sv -----
// Top level: configuration registers, controller and datapath of the motion detector.
//
// Luma pixels enter in raster order; each is compared with the same pixel of the
// previous frame held in an on-chip frame store of MAX_WIDTH*MAX_HEIGHT bytes,
// and one result leaves after the last pixel of every frame. Each pixel is first
// read from the frame store (its read data is registered), then the difference is
// added and the new pixel written back; no new pixel is accepted before the
// previous one has been written back. After the last pixel of a frame the block
// forms the motion bound (threshold times width times height, two registered
// multiplies) and loads the output register, once any previous result has been
// taken. The first frame after reset only fills the store and
// reports compared = 0. Width, height and threshold sit at byte addresses 0, 4
// and 8 of the configuration port and should be written between frames.
module frame_difference_motion_detect_top
  import fdmd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LUMA_W-1:0] in_luma,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_compared,
  output logic              out_motion_detected,
  output logic [SUM_W-1:0]  out_difference_sum
);

  logic [FW_W-1:0]  width_r;
  logic [FH_W-1:0]  height_r;
  logic [THR_W-1:0] thr_r;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  fdmd_cmd_t        cmd;
  fdmd_status_t     status;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FW_RESET;
      height_r <= FH_RESET;
      thr_r    <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:     width_r  <= cfg_pwdata[FW_W-1:0];
        REG_HEIGHT:    height_r <= cfg_pwdata[FH_W-1:0];
        REG_THRESHOLD: thr_r    <= cfg_pwdata[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:     cfg_prdata = APB_DW'(width_r);
      REG_HEIGHT:    cfg_prdata = APB_DW'(height_r);
      REG_THRESHOLD: cfg_prdata = APB_DW'(thr_r);
      default:       cfg_prdata = '0;
    endcase
  end

  fdmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fdmd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .frame_width         (width_r),
    .frame_height        (height_r),
    .motion_threshold    (thr_r),
    .in_luma             (in_luma),
    .cmd                 (cmd),
    .status              (status),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_compared        (out_compared),
    .out_motion_detected (out_motion_detected),
    .out_difference_sum  (out_difference_sum)
  );

  // Only one controller command is issued in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.accumulate, cmd.load_bound, cmd.load_out}))
    else $error("more than one datapath command at once");

  // A pixel transfer is followed by its accumulate cycle, never by another transfer.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && cmd.accumulate))
    else $error("pixel accepted before the previous one was accumulated");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("frame result loaded over a pending one");

  // The first frame reports neither motion nor a sum.
  a_first_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_compared) |-> (!out_motion_detected && out_difference_sum == '0))
    else $error("uncompared frame reports motion or a sum");

endmodule
